// File: rtl/wvm_pkg.sv
// wvm_pkg: shared types, register map and the byte expansion table of the
// wavetable voice mixer. No dependencies.
package wvm_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE_REG = 2'd0,
    ACT_READ_REG  = 2'd1,
    ACT_WRITE_MEM = 2'd2,
    ACT_TICK      = 2'd3
  } action_t;

  localparam int REGS_PER_VOICE = 32;
  // registers 0 .. 0x17 are all a tick needs
  localparam int REG_CACHE = 24;
  localparam int WB_COUNT  = 9;

  localparam logic [4:0] REG_FLAGS   = 5'h00;
  localparam logic [4:0] REG_POS_HI  = 5'h01;
  localparam logic [4:0] REG_POS_MID = 5'h02;
  localparam logic [4:0] REG_POS_LO  = 5'h03;
  localparam logic [4:0] REG_PITCH   = 5'h08;
  localparam logic [4:0] REG_LOOP_HI = 5'h09;
  localparam logic [4:0] REG_LOOP_MID = 5'h0a;
  localparam logic [4:0] REG_LOOP_LO = 5'h0b;
  localparam logic [4:0] REG_RAMP    = 5'h0c;
  localparam logic [4:0] REG_END_HI  = 5'h0d;
  localparam logic [4:0] REG_END_MID = 5'h0e;
  localparam logic [4:0] REG_END_LO  = 5'h0f;
  localparam logic [4:0] REG_VOL_R0  = 5'h10;
  localparam logic [4:0] REG_DVOL_R0 = 5'h11;
  localparam logic [4:0] REG_VOL_L0  = 5'h12;
  localparam logic [4:0] REG_DVOL_L0 = 5'h13;
  localparam logic [4:0] REG_VOL_R1  = 5'h14;
  localparam logic [4:0] REG_DVOL_R1 = 5'h15;
  localparam logic [4:0] REG_VOL_L1  = 5'h16;
  localparam logic [4:0] REG_DVOL_L1 = 5'h17;
  localparam logic [4:0] REG_LAST    = 5'h17;

  localparam logic [15:0] FMT_MASK   = 16'h8400;
  localparam logic [15:0] FMT_LINEAR = 16'h0000;
  localparam logic [15:0] FMT_TABLE  = 16'h8400;
  localparam int FLAG_ACTIVE = 0;
  localparam int FLAG_LOOP   = 3;

  // registers a tick writes back, in order
  function automatic logic [4:0] wb_reg(input logic [3:0] n);
    logic [4:0] r;
    unique case (n)
      4'd0:    r = REG_FLAGS;
      4'd1:    r = REG_POS_HI;
      4'd2:    r = REG_POS_MID;
      4'd3:    r = REG_POS_LO;
      4'd4:    r = REG_RAMP;
      4'd5:    r = REG_VOL_R0;
      4'd6:    r = REG_VOL_L0;
      4'd7:    r = REG_VOL_R1;
      4'd8:    r = REG_VOL_L1;
      default: r = REG_FLAGS;
    endcase
    return r;
  endfunction

  // compressed byte to 16-bit sample: segment base plus scaled low nibble
  function automatic logic [15:0] expand_byte(input logic [7:0] b);
    logic [15:0] base;
    logic [15:0] lin;
    unique case (b[7:4])
      4'h0: base = 16'h8000;
      4'h1: base = 16'h4000;
      4'h2: base = 16'hc000;
      4'h3: base = 16'h2000;
      4'h4: base = 16'he000;
      4'h5: base = 16'h1000;
      4'h6: base = 16'hf000;
      4'h7: base = 16'h0800;
      4'h8: base = 16'hf800;
      4'h9: base = 16'h0400;
      4'ha: base = 16'hfc00;
      4'hb: base = 16'h0200;
      4'hc: base = 16'hfe00;
      4'hd: base = 16'h0100;
      4'he: base = 16'h0000;
      4'hf: base = 16'hff80;
      default: base = 16'h0000;
    endcase
    lin = {12'd0, b[3:0]} << (4'd10 - {1'b0, b[7:5]});
    return base + lin;
  endfunction

endpackage

// File: rtl/wvm_ifs.sv
// wvm_req_if / wvm_rsp_if: valid-ready channels of the wavetable voice mixer.
// No dependencies.
interface wvm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [4:0]  voice;
  logic [4:0]  reg_index;
  logic [15:0] reg_value;
  logic [23:0] mem_address;
  logic [7:0]  mem_data;
  modport source(output valid, action, voice, reg_index, reg_value, mem_address, mem_data,
                 input ready);
  modport sink(input valid, action, voice, reg_index, reg_value, mem_address, mem_data,
               output ready);
endinterface

interface wvm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] mix_left;
  logic signed [20:0] mix_right;
  logic [15:0]        read_value;
  logic               is_tick;
  modport source(output valid, mix_left, mix_right, read_value, is_tick, input ready);
  modport sink(input valid, mix_left, mix_right, read_value, is_tick, output ready);
endinterface

// File: rtl/wavetable_voice_mixer.sv
// Wavetable voice mixer: register writes and memory byte writes are done when the item is
// taken; a read gives its result through the result and output registers. A tick reads
// only the flags of an inactive voice; an active voice takes 24 register reads through
// the single voice RAM read port, zero to four sample byte fetches, five multiplier
// passes and nine write-backs, and it uses the bit-serial remainder unit when a loop
// wrap needs it. After reset a clearing pass zeroes all VOICE_COUNT*32 voice registers,
// during which no item is taken. Depends on wvm_pkg, wvm_ifs and wvm_ram.
module wavetable_voice_mixer #(
  parameter int VOICE_COUNT      = 32,
  parameter int SAMPLE_MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  wvm_req_if.sink     req,
  wvm_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);
  localparam int VIW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VAW    = VIW + 5;
  localparam int VDEPTH = VOICE_COUNT * wvm_pkg::REGS_PER_VOICE;
  localparam int SAW    = $clog2(SAMPLE_MEM_BYTES);
  localparam logic [24:0]    MEM_BYTES  = 25'(SAMPLE_MEM_BYTES);
  localparam logic [VIW-1:0] LAST_VOICE = VIW'(VOICE_COUNT - 1);
  localparam logic [VAW-1:0] LAST_ENTRY = VAW'(VDEPTH - 1);
  localparam logic signed [25:0] SUM_MAX = 26'sd1048575;
  localparam logic signed [25:0] SUM_MIN = -26'sd1048576;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_RCAP, S_VREQ, S_VCAP, S_FSET, S_FREQ, S_FCAP, S_SMP,
    S_INTERP, S_STEP, S_DIV, S_ML1, S_ML2, S_MR1, S_MR2, S_RAMP, S_WB, S_TEND, S_RES
  } state_t;

  state_t state;
  logic [16:0] sample_mem_size;
  logic [VAW-1:0] ccnt;
  logic [VIW-1:0] vcnt;
  logic [4:0] ridx;
  logic [15:0] lr [wvm_pkg::REG_CACHE];
  logic rd_ok;
  logic [33:0] fbase;
  logic [1:0] fcnt, fnum;
  logic [3:0] fvld;
  logic [7:0] fb [4];
  logic signed [15:0] s0, s1;
  logic signed [16:0] samp;
  logic signed [50:0] prod;
  logic [48:0] cur, diff, dq;
  logic [47:0] span, rem;
  logic cur_ge, lp_lt, diff_lt;
  logic [5:0] dcnt;
  logic [3:0] wcnt;
  logic signed [25:0] suml, sumr;
  logic signed [20:0] res_left, res_right;
  logic [15:0] res_read;
  logic res_tick;
  logic o_valid;
  logic signed [20:0] o_left, o_right;
  logic [15:0] o_read;
  logic o_tick;

  logic accept, v_in_range;
  logic [24:0] lim;
  logic [47:0] pos, endp, lpp;
  logic [23:0] step;
  logic [33:0] fa;
  logic f_ok;
  logic [15:0] fmt;
  logic signed [15:0] s0_c, s1_c;
  logic signed [16:0] d01;
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;
  logic [48:0] rem_sh;
  logic [47:0] rem_nx;
  logic [4:0] wb_idx;
  logic vr_we;
  logic [VAW-1:0] vr_waddr, vr_raddr;
  logic [15:0] vr_wdata, vr_rdata;
  logic sm_we;
  logic [7:0] sm_rdata;

  function automatic logic signed [20:0] sat21(input logic signed [25:0] v);
    logic signed [20:0] r;
    if (v > SUM_MAX) begin
      r = 21'(SUM_MAX);
    end else if (v < SUM_MIN) begin
      r = 21'(SUM_MIN);
    end else begin
      r = 21'(v);
    end
    return r;
  endfunction

  assign accept     = req.valid && req.ready;
  assign v_in_range = {2'b0, req.voice} < 7'(VOICE_COUNT);
  assign lim = (25'(sample_mem_size) < MEM_BYTES) ? 25'(sample_mem_size) : MEM_BYTES;
  assign pos  = {lr[wvm_pkg::REG_POS_HI], lr[wvm_pkg::REG_POS_MID], lr[wvm_pkg::REG_POS_LO]};
  assign endp = {lr[wvm_pkg::REG_END_HI], lr[wvm_pkg::REG_END_MID], lr[wvm_pkg::REG_END_LO]};
  assign lpp  = {lr[wvm_pkg::REG_LOOP_HI], lr[wvm_pkg::REG_LOOP_MID],
                 lr[wvm_pkg::REG_LOOP_LO]};
  assign fmt  = lr[wvm_pkg::REG_FLAGS] & wvm_pkg::FMT_MASK;

  // pitch step: 1.mantissa, shifted left 0..7 or right 1..8
  always_comb begin
    logic [23:0] base;
    logic [3:0]  sh;
    base = {7'd0, 1'b1, lr[wvm_pkg::REG_PITCH][15:4], 4'd0};
    sh   = lr[wvm_pkg::REG_PITCH][3:0];
    if (sh[3]) begin
      step = base >> (5'd16 - {1'b0, sh});
    end else begin
      step = base << sh;
    end
  end

  assign fa   = fbase + {32'd0, fcnt};
  assign f_ok = fa < {9'd0, lim};

  // neighbor samples; out-of-range bytes were stored as zero
  always_comb begin
    s0_c = '0;
    s1_c = '0;
    if (fmt == wvm_pkg::FMT_LINEAR) begin
      if (fvld[1]) s0_c = {fb[0], fb[1]};
      if (fvld[3]) s1_c = {fb[2], fb[3]};
    end else if (fmt == wvm_pkg::FMT_TABLE) begin
      s0_c = wvm_pkg::expand_byte(fb[0]);
      s1_c = wvm_pkg::expand_byte(fb[1]);
    end
  end

  assign d01 = {s1[15], s1} - {s0[15], s0};

  // shared multiplier
  always_comb begin
    unique case (state)
      S_INTERP: begin
        mul_a = {{17{d01[16]}}, d01};
        mul_b = {1'b0, lr[wvm_pkg::REG_POS_LO]};
      end
      S_ML1: begin
        mul_a = {{17{samp[16]}}, samp};
        mul_b = {1'b0, lr[wvm_pkg::REG_VOL_L0]};
      end
      S_ML2: begin
        mul_a = prod[33:0];
        mul_b = {1'b0, lr[wvm_pkg::REG_VOL_L1]};
      end
      S_MR1: begin
        mul_a = {{17{samp[16]}}, samp};
        mul_b = {1'b0, lr[wvm_pkg::REG_VOL_R0]};
      end
      S_MR2: begin
        mul_a = prod[33:0];
        mul_b = {1'b0, lr[wvm_pkg::REG_VOL_R1]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one restoring remainder step per cycle
  assign rem_sh = {rem, dq[48]};
  assign rem_nx = (rem_sh >= {1'b0, span}) ? 48'(rem_sh - {1'b0, span}) : rem_sh[47:0];

  assign wb_idx = wvm_pkg::wb_reg(wcnt);

  always_comb begin
    vr_we    = 1'b0;
    vr_waddr = {VIW'(req.voice), req.reg_index};
    vr_wdata = req.reg_value;
    if (state == S_CLEAR) begin
      vr_we    = 1'b1;
      vr_waddr = ccnt;
      vr_wdata = '0;
    end else if (state == S_WB) begin
      vr_we    = 1'b1;
      vr_waddr = {vcnt, wb_idx};
      vr_wdata = lr[wb_idx];
    end else if (accept && req.action == wvm_pkg::ACT_WRITE_REG && v_in_range) begin
      vr_we = 1'b1;
    end
  end
  assign vr_raddr = (state == S_IDLE) ? {VIW'(req.voice), req.reg_index} : {vcnt, ridx};
  assign sm_we = accept && req.action == wvm_pkg::ACT_WRITE_MEM
                 && {1'b0, req.mem_address} < MEM_BYTES;

  wvm_ram #(.WIDTH(16), .DEPTH(VDEPTH)) u_vregs (
    .clk(clk), .we(vr_we), .waddr(vr_waddr), .wdata(vr_wdata),
    .raddr(vr_raddr), .rdata(vr_rdata)
  );

  wvm_ram #(.WIDTH(8), .DEPTH(SAMPLE_MEM_BYTES)) u_smem (
    .clk(clk), .we(sm_we), .waddr(req.mem_address[SAW-1:0]), .wdata(req.mem_data),
    .raddr(fa[SAW-1:0]), .rdata(sm_rdata)
  );

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = o_valid;
  assign rsp.mix_left   = o_left;
  assign rsp.mix_right  = o_right;
  assign rsp.read_value = o_read;
  assign rsp.is_tick    = o_tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_mem_size <= '0;
    end else if (cfg_we) begin
      sample_mem_size <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      ccnt    <= '0;
      vcnt    <= '0;
      ridx    <= '0;
      fcnt    <= '0;
      dcnt    <= '0;
      wcnt    <= '0;
      o_valid <= 1'b0;
    end else begin
      // in S_RES with ready high the output register is reloaded instead
      if (rsp.ready && state != S_RES) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          ccnt <= ccnt + 1'b1;
          if (ccnt == LAST_ENTRY) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (req.action == wvm_pkg::ACT_READ_REG) begin
              rd_ok <= v_in_range;
              state <= S_RCAP;
            end else if (req.action == wvm_pkg::ACT_TICK) begin
              suml <= '0;
              sumr <= '0;
              vcnt <= '0;
              ridx <= '0;
              state <= (lim == '0) ? S_TEND : S_VREQ;
            end
          end
        end
        S_RCAP: begin
          res_left  <= '0;
          res_right <= '0;
          res_read  <= rd_ok ? vr_rdata : '0;
          res_tick  <= 1'b0;
          state     <= S_RES;
        end
        S_VREQ: state <= S_VCAP;
        S_VCAP: begin
          lr[ridx] <= vr_rdata;
          if (ridx == wvm_pkg::REG_FLAGS && !vr_rdata[wvm_pkg::FLAG_ACTIVE]) begin
            if (vcnt == LAST_VOICE) begin
              state <= S_TEND;
            end else begin
              vcnt  <= vcnt + 1'b1;
              state <= S_VREQ;
            end
          end else if (ridx == wvm_pkg::REG_LAST) begin
            state <= S_FSET;
          end else begin
            ridx  <= ridx + 1'b1;
            state <= S_VREQ;
          end
        end
        S_FSET: begin
          cur  <= {1'b0, pos} + {25'd0, step};
          fcnt <= '0;
          fvld <= '0;
          fb[0] <= '0;
          fb[1] <= '0;
          fb[2] <= '0;
          fb[3] <= '0;
          if (fmt == wvm_pkg::FMT_LINEAR) begin
            fbase <= {1'b0, pos[47:16], 1'b0};
            fnum  <= 2'd3;
            state <= S_FREQ;
          end else if (fmt == wvm_pkg::FMT_TABLE) begin
            fbase <= {2'b0, pos[47:16]};
            fnum  <= 2'd1;
            state <= S_FREQ;
          end else begin
            state <= S_SMP;
          end
        end
        S_FREQ: begin
          fvld[fcnt] <= f_ok;
          state      <= S_FCAP;
        end
        S_FCAP: begin
          fb[fcnt] <= fvld[fcnt] ? sm_rdata : '0;
          if (fcnt == fnum) begin
            state <= S_SMP;
          end else begin
            fcnt  <= fcnt + 1'b1;
            state <= S_FREQ;
          end
        end
        S_SMP: begin
          s0      <= s0_c;
          s1      <= s1_c;
          cur_ge  <= cur >= {1'b0, endp};
          diff    <= cur - {1'b0, endp};
          lp_lt   <= lpp < endp;
          span    <= endp - lpp;
          state   <= S_INTERP;
        end
        S_INTERP: begin
          prod    <= mul_p;
          diff_lt <= diff < {1'b0, span};
          state   <= S_STEP;
        end
        S_STEP: begin
          samp  <= {s0[15], s0} + prod[32:16];
          state <= S_ML1;
          if (!cur_ge) begin
            {lr[1], lr[2], lr[3]} <= cur[47:0];
          end else if (lr[wvm_pkg::REG_FLAGS][wvm_pkg::FLAG_LOOP]) begin
            if (!lp_lt) begin
              {lr[1], lr[2], lr[3]} <= 48'(diff + {1'b0, lpp});
            end else if (diff_lt) begin
              {lr[1], lr[2], lr[3]} <= lpp + diff[47:0];
            end else begin
              rem   <= '0;
              dq    <= diff;
              dcnt  <= '0;
              state <= S_DIV;
            end
          end else begin
            // end without loop: voice goes silent
            lr[wvm_pkg::REG_FLAGS][wvm_pkg::FLAG_ACTIVE] <= 1'b0;
            lr[wvm_pkg::REG_RAMP]   <= '0;
            lr[wvm_pkg::REG_VOL_R0] <= '0;
            lr[wvm_pkg::REG_VOL_L0] <= '0;
            lr[wvm_pkg::REG_VOL_R1] <= '0;
            lr[wvm_pkg::REG_VOL_L1] <= '0;
            {lr[1], lr[2], lr[3]} <= cur[47:0];
          end
        end
        S_DIV: begin
          rem  <= rem_nx;
          dq   <= {dq[47:0], 1'b0};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'd48) begin
            {lr[1], lr[2], lr[3]} <= lpp + rem_nx;
            state <= S_ML1;
          end
        end
        S_ML1: begin
          prod  <= mul_p;
          state <= S_ML2;
        end
        S_ML2: begin
          suml  <= suml + {{9{mul_p[48]}}, mul_p[48:32]};
          state <= S_MR1;
        end
        S_MR1: begin
          prod  <= mul_p;
          state <= S_MR2;
        end
        S_MR2: begin
          sumr  <= sumr + {{9{mul_p[48]}}, mul_p[48:32]};
          state <= S_RAMP;
        end
        S_RAMP: begin
          if (lr[wvm_pkg::REG_RAMP] != '0) begin
            lr[wvm_pkg::REG_VOL_R0] <= lr[wvm_pkg::REG_VOL_R0] + lr[wvm_pkg::REG_DVOL_R0];
            lr[wvm_pkg::REG_VOL_L0] <= lr[wvm_pkg::REG_VOL_L0] + lr[wvm_pkg::REG_DVOL_L0];
            lr[wvm_pkg::REG_VOL_R1] <= lr[wvm_pkg::REG_VOL_R1] + lr[wvm_pkg::REG_DVOL_R1];
            lr[wvm_pkg::REG_VOL_L1] <= lr[wvm_pkg::REG_VOL_L1] + lr[wvm_pkg::REG_DVOL_L1];
            lr[wvm_pkg::REG_RAMP]   <= lr[wvm_pkg::REG_RAMP] - 1'b1;
          end
          wcnt  <= '0;
          state <= S_WB;
        end
        S_WB: begin
          if (wcnt == 4'(wvm_pkg::WB_COUNT - 1)) begin
            ridx <= '0;
            if (vcnt == LAST_VOICE) begin
              state <= S_TEND;
            end else begin
              vcnt  <= vcnt + 1'b1;
              state <= S_VREQ;
            end
          end else begin
            wcnt <= wcnt + 1'b1;
          end
        end
        S_TEND: begin
          res_left  <= sat21(suml);
          res_right <= sat21(sumr);
          res_read  <= '0;
          res_tick  <= 1'b1;
          state     <= S_RES;
        end
        S_RES: begin
          // hold the result until the output register is free
          if (!o_valid || rsp.ready) begin
            o_valid <= 1'b1;
            o_left  <= res_left;
            o_right <= res_right;
            o_read  <= res_read;
            o_tick  <= res_tick;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_take_while_clearing: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !req.ready)
    else $error("item taken during clearing pass");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < span)
    else $error("remainder not below loop span");

  a_read_silent: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.is_tick |-> rsp.mix_left == '0 && rsp.mix_right == '0)
    else $error("read result carries mix data");

  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    state == S_RES && (!o_valid || rsp.ready) |=> o_valid && state == S_IDLE)
    else $error("pending result not moved to output");
endmodule

// File: rtl/wvm_ram.sv
// wvm_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
module wvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: test/tb_top.sv
// tb_top: self-checking testbench of the wavetable voice mixer.
// Depends on wvm_pkg, wvm_ifs and wavetable_voice_mixer. Items go in on the request
// channel; every result is checked against the mixer model or a directed-table literal.
`timescale 1ns / 100ps

module tb_top;

  localparam int VOICES    = 32;
  localparam int MEM_BYTES = 65536;
  localparam logic [63:0] POS_MASK = 64'h0000_ffff_ffff_ffff;
  localparam longint MIX_MAX = 1048575;
  localparam longint MIX_MIN = -1048576;
  localparam logic [15:0] FMT_BIT15 = 16'h8000;
  localparam logic [15:0] FMT_BIT10 = 16'h0400;
  localparam logic [15:0] SEG_BASE [16] = '{
    16'h8000, 16'h4000, 16'hc000, 16'h2000, 16'he000, 16'h1000, 16'hf000, 16'h0800,
    16'hf800, 16'h0400, 16'hfc00, 16'h0200, 16'hfe00, 16'h0100, 16'h0000, 16'hff80};

  typedef struct {
    wvm_pkg::action_t act;
    logic [4:0]  voice;
    logic [4:0]  idx;
    logic [15:0] value;
    logic [23:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct {
    logic signed [20:0] ml;
    logic signed [20:0] mr;
    logic [15:0]        rv;
    logic               tk;
  } result_t;

  typedef struct {
    bit          is_cfg;
    logic [16:0] size;
    item_t       it;
    bit          lit;
    result_t     res;
  } row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [16:0] cfg_wdata;

  wvm_req_if req_ch ();
  wvm_rsp_if rsp_ch ();

  wavetable_voice_mixer uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // mixer model state
  logic [15:0] vregs [VOICES*wvm_pkg::REGS_PER_VOICE];
  logic [7:0]  smem [MEM_BYTES];
  bit          written [MEM_BYTES];
  logic [16:0] mem_size;

  result_t pending_results [$];
  int      errors;
  bit      squeeze_req;
  row_t    dir_rows [$];

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #50000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] mem_limit();
    return (mem_size < MEM_BYTES) ? 64'(mem_size) : 64'(MEM_BYTES);
  endfunction

  function automatic longint fetch_byte(input logic [63:0] a);
    if (a < mem_limit()) return longint'(smem[a[15:0]]);
    return 0;
  endfunction

  function automatic longint fetch_word(input logic [63:0] a);
    logic signed [15:0] w;
    if (a + 1 < mem_limit()) begin
      w = {smem[a[15:0]], smem[a[15:0] + 16'd1]};
      return w;
    end
    return 0;
  endfunction

  // segment base plus low nibble scaled by the segment step
  function automatic longint expand_sample(input longint b);
    logic [7:0]         bb;
    logic [15:0]        inc;
    logic signed [15:0] s;
    bb  = b[7:0];
    inc = 16'h0400 >> bb[7:5];
    s   = SEG_BASE[bb[7:4]] + 16'(bb[3:0]) * inc;
    return s;
  endfunction

  function automatic void play_voice(input int k, output longint lsum, output longint rsum);
    int          b;
    logic [63:0] cur;
    logic [63:0] adr;
    logic [63:0] end_p;
    logic [63:0] lp;
    logic [31:0] stp;
    logic [3:0]  sh;
    longint      s0;
    longint      s1;
    longint      samp;
    longint      fr;
    longint      va;
    longint      vb;
    b   = k * wvm_pkg::REGS_PER_VOICE;
    cur = {16'd0, vregs[b+wvm_pkg::REG_POS_HI], vregs[b+wvm_pkg::REG_POS_MID],
           vregs[b+wvm_pkg::REG_POS_LO]};
    adr = cur >> 16;
    s0  = 0;
    s1  = 0;
    if ((vregs[b+wvm_pkg::REG_FLAGS] & wvm_pkg::FMT_MASK) == wvm_pkg::FMT_LINEAR) begin
      s0 = fetch_word(2 * adr);
      s1 = fetch_word(2 * adr + 2);
    end else if ((vregs[b+wvm_pkg::REG_FLAGS] & wvm_pkg::FMT_MASK) == wvm_pkg::FMT_TABLE) begin
      s0 = expand_sample(fetch_byte(adr));
      s1 = expand_sample(fetch_byte(adr + 1));
    end
    fr   = cur[15:0];
    samp = s0 + (((s1 - s0) * fr) >>> 16);

    stp = 32'h10000 | {16'd0, vregs[b+wvm_pkg::REG_PITCH] & 16'hfff0};
    sh  = vregs[b+wvm_pkg::REG_PITCH][3:0];
    if (sh >= 8) stp = stp >> (16 - sh);
    else stp = stp << sh;
    cur = cur + stp;

    end_p = {16'd0, vregs[b+wvm_pkg::REG_END_HI], vregs[b+wvm_pkg::REG_END_MID],
             vregs[b+wvm_pkg::REG_END_LO]};
    if (cur >= end_p) begin
      if (vregs[b+wvm_pkg::REG_FLAGS][wvm_pkg::FLAG_LOOP]) begin
        lp = {16'd0, vregs[b+wvm_pkg::REG_LOOP_HI], vregs[b+wvm_pkg::REG_LOOP_MID],
              vregs[b+wvm_pkg::REG_LOOP_LO]};
        if (lp < end_p) cur = lp + (cur - end_p) % (end_p - lp);
        else cur = (cur - end_p + lp) & POS_MASK;
      end else begin
        vregs[b+wvm_pkg::REG_FLAGS][wvm_pkg::FLAG_ACTIVE] = 1'b0;
        vregs[b+wvm_pkg::REG_RAMP]   = '0;
        vregs[b+wvm_pkg::REG_VOL_R0] = '0;
        vregs[b+wvm_pkg::REG_VOL_L0] = '0;
        vregs[b+wvm_pkg::REG_VOL_R1] = '0;
        vregs[b+wvm_pkg::REG_VOL_L1] = '0;
      end
    end
    vregs[b+wvm_pkg::REG_POS_HI]  = cur[47:32];
    vregs[b+wvm_pkg::REG_POS_MID] = cur[31:16];
    vregs[b+wvm_pkg::REG_POS_LO]  = cur[15:0];

    va   = vregs[b+wvm_pkg::REG_VOL_L0];
    vb   = vregs[b+wvm_pkg::REG_VOL_L1];
    lsum = (samp * va * vb) >>> 32;
    va   = vregs[b+wvm_pkg::REG_VOL_R0];
    vb   = vregs[b+wvm_pkg::REG_VOL_R1];
    rsum = (samp * va * vb) >>> 32;

    if (vregs[b+wvm_pkg::REG_RAMP] != 0) begin
      vregs[b+wvm_pkg::REG_VOL_R0] = vregs[b+wvm_pkg::REG_VOL_R0] + vregs[b+wvm_pkg::REG_DVOL_R0];
      vregs[b+wvm_pkg::REG_VOL_L0] = vregs[b+wvm_pkg::REG_VOL_L0] + vregs[b+wvm_pkg::REG_DVOL_L0];
      vregs[b+wvm_pkg::REG_VOL_R1] = vregs[b+wvm_pkg::REG_VOL_R1] + vregs[b+wvm_pkg::REG_DVOL_R1];
      vregs[b+wvm_pkg::REG_VOL_L1] = vregs[b+wvm_pkg::REG_VOL_L1] + vregs[b+wvm_pkg::REG_DVOL_L1];
      vregs[b+wvm_pkg::REG_RAMP]   = vregs[b+wvm_pkg::REG_RAMP] - 16'd1;
    end
  endfunction

  function automatic longint clamp_mix(input longint v);
    if (v > MIX_MAX) return MIX_MAX;
    if (v < MIX_MIN) return MIX_MIN;
    return v;
  endfunction

  // returns 1 when the item produces a result
  function automatic bit mixer_step(input item_t it, output result_t res);
    int     slot;
    longint suml;
    longint sumr;
    longint l;
    longint r;
    slot = int'(it.voice) * wvm_pkg::REGS_PER_VOICE + int'(it.idx);
    res  = '{ml: '0, mr: '0, rv: '0, tk: 1'b0};
    case (it.act)
      wvm_pkg::ACT_WRITE_REG: begin
        vregs[slot] = it.value;
        return 0;
      end
      wvm_pkg::ACT_READ_REG: begin
        res.rv = vregs[slot];
        return 1;
      end
      wvm_pkg::ACT_WRITE_MEM: begin
        if (it.addr < MEM_BYTES) begin
          smem[it.addr[15:0]]    = it.data;
          written[it.addr[15:0]] = 1'b1;
        end
        return 0;
      end
      default: begin
        suml = 0;
        sumr = 0;
        if (mem_limit() != 0) begin
          for (int k = 0; k < VOICES; k++) begin
            if (vregs[k*wvm_pkg::REGS_PER_VOICE + wvm_pkg::REG_FLAGS][wvm_pkg::FLAG_ACTIVE])
            begin
              play_voice(k, l, r);
              suml += l;
              sumr += r;
            end
          end
        end
        res.ml = 21'(clamp_mix(suml));
        res.mr = 21'(clamp_mix(sumr));
        res.tk = 1'b1;
        return 1;
      end
    endcase
  endfunction

  function automatic item_t make_item(input wvm_pkg::action_t a, input int v, input int i,
                                      input int val, input int ad, input int d);
    item_t it;
    it.act   = a;
    it.voice = 5'(v);
    it.idx   = 5'(i);
    it.value = 16'(val);
    it.addr  = 24'(ad);
    it.data  = 8'(d);
    return it;
  endfunction

  function automatic int idle_len();
    int c;
    c = $urandom_range(0, 99);
    if (c < 60) return 0;
    if (c < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] setup_value(input logic [4:0] ix);
    logic [15:0] val;
    int          c;
    val = 16'($urandom);
    c   = $urandom_range(0, 99);
    case (ix)
      wvm_pkg::REG_FLAGS: begin
        val = val & ~wvm_pkg::FMT_MASK;
        if (c < 45) val = val | wvm_pkg::FMT_TABLE;
        else if (c < 50) val = val | FMT_BIT15;
        else if (c < 55) val = val | FMT_BIT10;
        val[wvm_pkg::FLAG_ACTIVE] = ($urandom_range(0, 1) == 1);
      end
      wvm_pkg::REG_POS_HI, wvm_pkg::REG_LOOP_HI, wvm_pkg::REG_END_HI: if (c < 80) val = '0;
      wvm_pkg::REG_POS_MID, wvm_pkg::REG_LOOP_MID, wvm_pkg::REG_END_MID:
        if (c < 70) val = 16'($urandom_range(0, 16'h3fff));
      default: ;
    endcase
    return val;
  endfunction

  function automatic item_t random_item();
    int         c;
    logic [4:0] v;
    logic [4:0] ix;
    c  = $urandom_range(0, 99);
    v  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 5));
    ix = 5'($urandom_range(0, wvm_pkg::REG_LAST));
    if (c < 40) return make_item(wvm_pkg::ACT_WRITE_REG, v, ix, setup_value(ix), 0, 0);
    if (c < 60) return make_item(wvm_pkg::ACT_TICK, v, ix, $urandom, $urandom, $urandom);
    if (c < 78) return make_item(wvm_pkg::ACT_READ_REG, v, $urandom_range(0, 31), 0, 0, 0);
    if (c < 88) begin
      if ($urandom_range(0, 9) == 0)
        return make_item(wvm_pkg::ACT_WRITE_MEM, 0, 0, 0, $urandom_range(0, 24'hffffff),
                         $urandom);
      return make_item(wvm_pkg::ACT_WRITE_MEM, 0, 0, 0, $urandom_range(0, MEM_BYTES - 1),
                       $urandom);
    end
    // noise: any register of any voice, any value
    return make_item(wvm_pkg::ACT_WRITE_REG, $urandom_range(0, 31), $urandom_range(0, 31),
                     $urandom, $urandom, $urandom);
  endfunction

  // sample bytes that the next tick fetches get written first
  task automatic cover_fetches();
    int          b;
    int          n;
    logic [63:0] adr;
    logic [63:0] a;
    logic [15:0] fmt;
    result_t     none_r;
    none_r = '{ml: '0, mr: '0, rv: '0, tk: 1'b0};
    for (int k = 0; k < VOICES; k++) begin
      b   = k * wvm_pkg::REGS_PER_VOICE;
      fmt = vregs[b+wvm_pkg::REG_FLAGS] & wvm_pkg::FMT_MASK;
      adr = {32'd0, vregs[b+wvm_pkg::REG_POS_HI], vregs[b+wvm_pkg::REG_POS_MID]};
      n   = (fmt == wvm_pkg::FMT_LINEAR) ? 4 : ((fmt == wvm_pkg::FMT_TABLE) ? 2 : 0);
      if (!vregs[b+wvm_pkg::REG_FLAGS][wvm_pkg::FLAG_ACTIVE]) n = 0;
      for (int j = 0; j < n; j++) begin
        a = (n == 4) ? 2 * adr + 64'(j) : adr + 64'(j);
        if (a < mem_limit() && !written[a[15:0]])
          send_item(make_item(wvm_pkg::ACT_WRITE_MEM, 0, 0, 0, int'(a[15:0]), $urandom),
                    1'b0, none_r, 1'b0);
      end
    end
  endtask

  task automatic send_item(input item_t it, input bit lit, input result_t lres,
                           input bit gaps);
    result_t res;
    int      g;
    if (it.act == wvm_pkg::ACT_TICK && mem_limit() != 0) cover_fetches();
    req_ch.valid       <= 1'b1;
    req_ch.action      <= it.act;
    req_ch.voice       <= it.voice;
    req_ch.reg_index   <= it.idx;
    req_ch.reg_value   <= it.value;
    req_ch.mem_address <= it.addr;
    req_ch.mem_data    <= it.data;
    do @(posedge clk); while (!req_ch.ready);
    if (mixer_step(it, res)) pending_results.push_back(lit ? lres : res);
    if (gaps) begin
      g = idle_len();
      if (g > 0) begin
        req_ch.valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  endtask

  task automatic set_mem_size(input logic [16:0] v);
    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // writes give no result, so let the block settle before touching the size
    repeat (60) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    mem_size  = v;
  endtask

  task automatic add_row(input item_t it, input bit lit, input result_t res);
    row_t r;
    r.is_cfg = 1'b0;
    r.size   = '0;
    r.it     = it;
    r.lit    = lit;
    r.res    = res;
    dir_rows.push_back(r);
  endtask

  task automatic add_cfg_row(input logic [16:0] v);
    row_t r;
    r.is_cfg = 1'b1;
    r.size   = v;
    r.lit    = 1'b0;
    dir_rows.push_back(r);
  endtask

  // receiver: checks every transfer and throttles ready
  initial begin
    int      stall;
    bit      squeezed;
    result_t want;
    stall    = 0;
    squeezed = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no expectation waiting");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_ch.mix_left !== want.ml) begin
            $error("mix_left expected %0d actual %0d", want.ml, rsp_ch.mix_left);
            errors++;
          end
          if (rsp_ch.mix_right !== want.mr) begin
            $error("mix_right expected %0d actual %0d", want.mr, rsp_ch.mix_right);
            errors++;
          end
          if (rsp_ch.read_value !== want.rv) begin
            $error("read_value expected %h actual %h", want.rv, rsp_ch.read_value);
            errors++;
          end
          if (rsp_ch.is_tick !== want.tk) begin
            $error("is_tick expected %b actual %b", want.tk, rsp_ch.is_tick);
            errors++;
          end
        end
      end
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        stall    = 3000;
      end
      if (stall > 0) begin
        stall--;
        rsp_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        stall = idle_len();
        rsp_ch.ready <= 1'b0;
      end
    end
  end

  initial begin
    result_t     none;
    result_t     zero_tick;
    result_t     rd;
    logic [16:0] sizes [7];
    none      = '{ml: '0, mr: '0, rv: '0, tk: 1'b0};
    zero_tick = '{ml: '0, mr: '0, rv: '0, tk: 1'b1};
    errors       = 0;
    squeeze_req  = 1'b0;
    mem_size     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.action      = wvm_pkg::ACT_WRITE_REG;
    req_ch.voice       = '0;
    req_ch.reg_index   = '0;
    req_ch.reg_value   = '0;
    req_ch.mem_address = '0;
    req_ch.mem_data    = '0;
    foreach (vregs[i]) vregs[i] = '0;
    foreach (smem[i]) smem[i] = '0;
    foreach (written[i]) written[i] = 1'b0;
    rst = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // byte writes beyond the memory are dropped
    send_item(make_item(wvm_pkg::ACT_WRITE_MEM, 0, 0, 0, 24'hffffff, 8'hff), 1'b0, none,
              1'b0);
    send_item(make_item(wvm_pkg::ACT_WRITE_MEM, 0, 0, 0, MEM_BYTES, 8'h00), 1'b0, none,
              1'b0);

    // directed table; size is still zero at the start
    add_row(make_item(wvm_pkg::ACT_READ_REG, 0, wvm_pkg::REG_FLAGS, 0, 0, 0), 1'b1, none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 31, 31, 16'hffff, 0, 0), 1'b0, none);
    rd = none;
    rd.rv = 16'hffff;
    add_row(make_item(wvm_pkg::ACT_READ_REG, 31, 31, 0, 0, 0), 1'b1, rd);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_FLAGS, 16'h0001, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_VOL_L0, 16'hffff, 0, 0), 1'b0,
            none);
    // size zero: silent tick, voices untouched
    add_row(make_item(wvm_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b1, zero_tick);
    add_row(make_item(wvm_pkg::ACT_READ_REG, 0, wvm_pkg::REG_POS_LO, 0, 0, 0), 1'b1, none);
    add_cfg_row(17'd65536);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_VOL_L1, 16'hffff, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_VOL_R0, 16'hffff, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_VOL_R1, 16'hffff, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_PITCH, 16'hfff7, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 0, wvm_pkg::REG_END_LO, 16'h0004, 0, 0), 1'b0,
            none);
    // end reached without loop
    add_row(make_item(wvm_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(make_item(wvm_pkg::ACT_READ_REG, 0, wvm_pkg::REG_FLAGS, 0, 0, 0), 1'b0, none);
    add_row(make_item(wvm_pkg::ACT_READ_REG, 0, wvm_pkg::REG_VOL_L0, 0, 0, 0), 1'b0, none);
    // table format, looping with the loop point beyond the end, ramping
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 1, wvm_pkg::REG_FLAGS, 16'h8409, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 1, wvm_pkg::REG_LOOP_HI, 16'hffff, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 1, wvm_pkg::REG_END_MID, 16'h0010, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 1, wvm_pkg::REG_RAMP, 16'h0003, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 1, wvm_pkg::REG_DVOL_L0, 16'h8000, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 1, wvm_pkg::REG_VOL_L1, 16'hffff, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, none);
    add_row(make_item(wvm_pkg::ACT_READ_REG, 1, wvm_pkg::REG_POS_HI, 0, 0, 0), 1'b0, none);
    // a format that gives a zero sample
    add_row(make_item(wvm_pkg::ACT_WRITE_REG, 2, wvm_pkg::REG_FLAGS, 16'h8001, 0, 0), 1'b0,
            none);
    add_row(make_item(wvm_pkg::ACT_TICK, 0, 0, 0, 0, 0), 1'b0, none);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) set_mem_size(dir_rows[i].size);
      else send_item(dir_rows[i].it, dir_rows[i].lit, dir_rows[i].res, 1'b1);
    end

    sizes = '{17'd65536, 17'd1, 17'd2, 17'($urandom_range(3, 65535)), 17'h1ffff, 17'd0,
              17'($urandom_range(256, 4096))};
    for (int p = 0; p < 7; p++) begin
      set_mem_size(sizes[p]);
      // long receiver hold-off while items keep coming
      if (p == 0) squeeze_req = 1'b1;
      for (int n = 0; n < 60; n++) send_item(random_item(), 1'b0, none, 1'b1);
    end

    req_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
